// ===== rtl/id3fx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3fx_pkg
// Shared types and constants of the ID3v2 tag frame extractor.
// ----------------------------------------------------------------------------
package id3fx_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [1:0]  t_kind;
    typedef logic [31:0] t_id;
    typedef logic [27:0] t_size;
    typedef logic [28:0] t_pos;
    typedef logic [3:0]  t_count;
    typedef logic [2:0]  t_phase;
    typedef logic [0:0]  t_cfg_index;
    typedef logic [31:0] t_cfg_data;

    // Result kinds.
    localparam t_kind KIND_BODY      = 2'd0;
    localparam t_kind KIND_NO_MARKER = 2'd1;
    localparam t_kind KIND_NOT_FOUND = 2'd2;

    // Configuration register indexes.
    localparam t_cfg_index REG_MODE   = 1'd0;
    localparam t_cfg_index REG_TARGET = 1'd1;

    // Parser phases.
    localparam t_phase PH_MARKER = 3'd0;
    localparam t_phase PH_SKIP   = 3'd1;
    localparam t_phase PH_TSIZE  = 3'd2;
    localparam t_phase PH_FID    = 3'd3;
    localparam t_phase PH_FSIZE  = 3'd4;
    localparam t_phase PH_FLAGS  = 3'd5;
    localparam t_phase PH_BODY   = 3'd6;

    // Marker characters, text frame prefix and body replacement.
    localparam t_byte CHAR_I     = 8'h49;
    localparam t_byte CHAR_D     = 8'h44;
    localparam t_byte CHAR_3     = 8'h33;
    localparam t_byte CHAR_T     = 8'h54;
    localparam t_byte CHAR_SPACE = 8'h20;

    localparam t_pos   POS_MAX     = 29'h1FFF_FFFF;
    localparam t_pos   HEADER_LEN  = 29'd10;
    localparam t_count MARKER_LEN  = 4'd3;
    localparam t_count SKIP_LEN    = 4'd3;
    localparam t_count SIZE_LEN    = 4'd4;
    localparam t_count ID_LEN      = 4'd4;
    localparam t_count FLAGS_LEN   = 4'd2;

endpackage

// ===== rtl/id3fx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3fx_byte_if, id3fx_res_if, id3fx_cfg_if
// Valid/ready channels of the extractor: file bytes, results, register writes.
// ----------------------------------------------------------------------------
interface id3fx_byte_if;
    import id3fx_pkg::*;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface id3fx_res_if;
    import id3fx_pkg::*;
    logic  valid;
    logic  ready;
    t_kind kind;
    t_id   frame_id;
    t_byte body_byte;
    logic  first_of_frame;
    logic  last_of_frame;

    modport source (output valid, output kind, output frame_id, output body_byte,
                    output first_of_frame, output last_of_frame, input ready);
    modport sink   (input valid, input kind, input frame_id, input body_byte,
                    input first_of_frame, input last_of_frame, output ready);
endinterface

interface id3fx_cfg_if;
    import id3fx_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/id3v2_frame_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3v2_frame_extractor
// Parses an ID3v2 tag one file byte per word and delivers frame body bytes.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word contents
//  i_in     in   data_byte, start_of_file
//  o_out    out  kind, frame_id, body_byte, first_of_frame, last_of_frame
//  i_cfg    in   index (0 = mode, 1 = target_id), data
//
// Each accepted byte updates the parser state and loads any result it causes
// into the output register at the same clock edge, so one byte per cycle is
// sustained while the sink keeps reading. The parser takes a new byte whenever
// the output register is empty or being read in the same cycle; a stalled
// result blocks input only while it waits. Reset clears the parser and both
// registers, and the first byte after reset is parsed as the start of a file.
// Register writes are always accepted.
// ----------------------------------------------------------------------------
module id3v2_frame_extractor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    id3fx_byte_if.sink   i_in,
    id3fx_res_if.source  o_out,
    id3fx_cfg_if.sink    i_cfg
);
    import id3fx_pkg::*;

    // Configuration registers.
    logic  r_mode;
    t_id   r_target;

    // Parser state.
    t_phase r_phase,       n_phase;
    t_count r_field_count, n_field_count;
    t_size  r_tag_size,    n_tag_size;
    t_pos   r_position,    n_position;
    t_id    r_current_id,  n_current_id;
    t_size  r_body_rem,    n_body_rem;
    logic   r_emitting,    n_emitting;
    logic   r_finished,    n_finished;

    // Output register.
    logic  r_out_valid;
    t_kind r_kind;
    t_id   r_frame_id;
    t_byte r_body_byte;
    logic  r_first;
    logic  r_last;

    // State after an optional restart, before this byte is parsed.
    t_phase c_phase;
    t_count c_field_count;
    t_size  c_tag_size;
    t_pos   c_position;
    t_id    c_current_id;
    t_size  c_body_rem;
    logic   c_emitting;
    logic   c_finished;

    // Result of this byte.
    logic  w_res_valid;
    t_kind w_res_kind;
    t_id   w_res_id;
    t_byte w_res_byte;
    logic  w_res_first;
    logic  w_res_last;

    logic   w_fire;
    t_count w_count_inc;
    t_byte  w_marker_char;
    t_byte  b;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_fire      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign b           = i_in.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_target <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MODE:   r_mode   <= i_cfg.data[0];
                REG_TARGET: r_target <= i_cfg.data;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    always_comb begin
        if (i_in.start_of_file) begin
            c_phase       = PH_MARKER;
            c_field_count = '0;
            c_tag_size    = '0;
            c_position    = '0;
            c_current_id  = '0;
            c_body_rem    = '0;
            c_emitting    = 1'b0;
            c_finished    = 1'b0;
        end else begin
            c_phase       = r_phase;
            c_field_count = r_field_count;
            c_tag_size    = r_tag_size;
            c_position    = r_position;
            c_current_id  = r_current_id;
            c_body_rem    = r_body_rem;
            c_emitting    = r_emitting;
            c_finished    = r_finished;
        end
    end

    always_comb begin
        case (c_field_count)
            4'd0:    w_marker_char = CHAR_I;
            4'd1:    w_marker_char = CHAR_D;
            default: w_marker_char = CHAR_3;
        endcase
    end

    // One parse step. A frame boundary checks the tag end; a frame end in get
    // mode after the wanted frame stops the parser without a result.
    always_comb begin
        logic at_boundary;
        logic is_frame_end;
        logic tag_over;

        n_phase       = c_phase;
        n_field_count = c_field_count;
        n_tag_size    = c_tag_size;
        n_position    = c_position;
        n_current_id  = c_current_id;
        n_body_rem    = c_body_rem;
        n_emitting    = c_emitting;
        n_finished    = c_finished;
        w_res_valid   = 1'b0;
        w_res_kind    = KIND_BODY;
        w_res_id      = '0;
        w_res_byte    = '0;
        w_res_first   = 1'b0;
        w_res_last    = 1'b0;
        at_boundary   = 1'b0;
        is_frame_end  = 1'b0;
        tag_over      = 1'b0;
        w_count_inc   = c_field_count + 4'd1;

        if (!c_finished) begin
            if (c_position != POS_MAX) begin
                n_position = c_position + 29'd1;
            end
            case (c_phase)
                PH_MARKER: begin
                    if (c_field_count >= MARKER_LEN || b != w_marker_char) begin
                        n_finished  = 1'b1;
                        w_res_valid = 1'b1;
                        w_res_kind  = KIND_NO_MARKER;
                    end else if (w_count_inc == MARKER_LEN) begin
                        n_phase       = PH_SKIP;
                        n_field_count = '0;
                    end else begin
                        n_field_count = w_count_inc;
                    end
                end
                PH_SKIP: begin
                    n_field_count = w_count_inc;
                    if (w_count_inc >= SKIP_LEN) begin
                        n_phase       = PH_TSIZE;
                        n_field_count = '0;
                        n_tag_size    = '0;
                    end
                end
                PH_TSIZE: begin
                    n_tag_size    = {c_tag_size[20:0], b[6:0]};
                    n_field_count = w_count_inc;
                    at_boundary   = (w_count_inc >= SIZE_LEN);
                end
                PH_FID: begin
                    n_current_id  = {c_current_id[23:0], b};
                    n_field_count = w_count_inc;
                    if (w_count_inc >= ID_LEN) begin
                        n_phase       = PH_FSIZE;
                        n_field_count = '0;
                        n_body_rem    = '0;
                    end
                end
                PH_FSIZE: begin
                    n_body_rem    = {c_body_rem[20:0], b[6:0]};
                    n_field_count = w_count_inc;
                    if (w_count_inc >= SIZE_LEN) begin
                        n_phase       = PH_FLAGS;
                        n_field_count = '0;
                    end
                end
                PH_FLAGS: begin
                    n_field_count = w_count_inc;
                    if (w_count_inc >= FLAGS_LEN) begin
                        if (r_mode) begin
                            n_emitting = (c_current_id == r_target);
                        end else begin
                            n_emitting = (c_current_id[31:24] == CHAR_T);
                        end
                        n_field_count = '0;
                        if (c_body_rem == '0) begin
                            is_frame_end = 1'b1;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
                default: begin
                    if (c_emitting) begin
                        w_res_valid = 1'b1;
                        w_res_kind  = KIND_BODY;
                        w_res_id    = c_current_id;
                        w_res_first = (c_field_count == '0);
                        w_res_last  = (c_body_rem <= 28'd1);
                        w_res_byte  = w_res_first ? CHAR_SPACE : b;
                    end
                    n_field_count = 4'd1;
                    if (c_body_rem != '0) begin
                        n_body_rem = c_body_rem - 28'd1;
                    end
                    is_frame_end = (n_body_rem == '0);
                end
            endcase

            if (is_frame_end) begin
                if (n_emitting && r_mode) begin
                    n_finished = 1'b1;
                end else begin
                    at_boundary = 1'b1;
                end
            end

            if (at_boundary) begin
                tag_over = (n_position >= ({1'b0, n_tag_size} + HEADER_LEN));
                if (tag_over) begin
                    n_finished = 1'b1;
                    if (r_mode) begin
                        w_res_valid = 1'b1;
                        w_res_kind  = KIND_NOT_FOUND;
                        w_res_id    = '0;
                        w_res_byte  = '0;
                        w_res_first = 1'b0;
                        w_res_last  = 1'b0;
                    end
                end else begin
                    n_phase       = PH_FID;
                    n_field_count = '0;
                    n_current_id  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MARKER;
            r_field_count <= '0;
            r_tag_size    <= '0;
            r_position    <= '0;
            r_current_id  <= '0;
            r_body_rem    <= '0;
            r_emitting    <= 1'b0;
            r_finished    <= 1'b0;
        end else if (w_fire) begin
            r_phase       <= n_phase;
            r_field_count <= n_field_count;
            r_tag_size    <= n_tag_size;
            r_position    <= n_position;
            r_current_id  <= n_current_id;
            r_body_rem    <= n_body_rem;
            r_emitting    <= n_emitting;
            r_finished    <= n_finished;
        end
    end

    // Output register: loaded by any accepted byte, drained by the sink.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_kind      <= w_res_kind;
            r_frame_id  <= w_res_id;
            r_body_byte <= w_res_byte;
            r_first     <= w_res_first;
            r_last      <= w_res_last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_kind;
    assign o_out.frame_id       = r_frame_id;
    assign o_out.body_byte      = r_body_byte;
    assign o_out.first_of_frame = r_first;
    assign o_out.last_of_frame  = r_last;

    // A finished parser ignores bytes until a restart.
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_finished && !i_in.start_of_file) |=>
            (r_phase == $past(r_phase) && r_finished && r_out_valid == 1'b0))
        else $error("finished parser changed state or produced a result");

    // Inside a frame body the field counter only marks the first byte.
    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_field_count <= 4'd1))
        else $error("body field counter out of range");

    // A body byte is only delivered for a frame selected for output.
    a_body_selected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res_valid && w_res_kind == KIND_BODY) |=> r_emitting)
        else $error("body byte delivered for a frame that is not selected");

    // An error result always stops the parser.
    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res_valid && w_res_kind != KIND_BODY) |=> r_finished)
        else $error("error result without stopping the parser");

endmodule
